/* rtl/rbsd_pkg.sv */
`default_nettype none

package rbsd_pkg;

    // largest accepted board side from the header
    localparam logic [11:0] C_MAX_SIDE = 12'd255;
    localparam logic [8:0]  C_SAT9     = 9'd511;

    localparam logic [7:0] C_CH_B   = 8'h42;
    localparam logic [7:0] C_CH_X   = 8'h78;
    localparam logic [7:0] C_CH_BAR = 8'h7C;
    localparam logic [7:0] C_CH_W   = 8'h57;
    localparam logic [7:0] C_CH_E   = 8'h45;
    localparam logic [7:0] C_CH_S   = 8'h53;
    localparam logic [7:0] C_CH_0   = 8'h30;
    localparam logic [7:0] C_CH_9   = 8'h39;

    typedef enum logic [2:0] {
        PH_HDR_B,
        PH_HGT0,
        PH_HGT,
        PH_WID0,
        PH_WID,
        PH_ROWSTART,
        PH_RUN
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_DIMS,
        ERR_CHAR,
        ERR_SNAKE
    } t_err;

    typedef enum logic [1:0] {
        KIND_EMPTY,
        KIND_WALL,
        KIND_SNAKE
    } t_kind;

    // state of the row being parsed
    typedef struct packed {
        t_kind       kind;
        logic [8:0]  count;
        logic [8:0]  sum;
        t_err        pending;
        logic        snake;
        logic [15:0] idx;
    } t_row;

    typedef struct packed {
        t_row        row;
        logic        emit;
        t_kind       typ;
        logic [15:0] start;
        logic [7:0]  len;
    } t_close;

    // results of one byte: an optional cell run and an optional status
    typedef struct packed {
        logic        cell_v;
        t_kind       cell_type;
        logic [15:0] start_index;
        logic [7:0]  run_length;
        logic        status_v;
        t_err        status_code;
        logic [7:0]  board_width;
        logic [7:0]  board_height;
    } t_entry;

endpackage

`default_nettype wire

/* rtl/rbsd_if.sv */
`default_nettype none

interface rbsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface rbsd_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [1:0]  cell_type;
    logic [15:0] start_index;
    logic [7:0]  run_length;
    logic [1:0]  status_code;
    logic [7:0]  board_width;
    logic [7:0]  board_height;
    logic        last_result;

    modport source (
        output valid, output result_kind, output cell_type, output start_index,
        output run_length, output status_code, output board_width,
        output board_height, output last_result, input ready
    );
    modport sink (
        input valid, input result_kind, input cell_type, input start_index,
        input run_length, input status_code, input board_width,
        input board_height, input last_result, output ready
    );
endinterface

`default_nettype wire

/* rtl/rle_board_string_decoder.sv */
// channel  | dir | transfer                | payload
// i_in     | in  | valid & ready at clk    | char_code[7:0], is_last
// o_out    | out | valid & ready at clk    | result_kind, cell_type, start_index,
//          |     |                         | run_length, status_code, board_width,
//          |     |                         | board_height, last_result
//
// one byte per cycle while the result queue has room; a byte enters an input register and is parsed from there
// a byte gives up to two results (a cell run and, on the last byte, the status);
// those go out one per cycle, while o_out is ready, from a two-entry result queue
// input stalls only while the input register holds a byte and the result queue is full
// reset is synchronous, active low, and leaves the parser waiting for a header
`default_nettype none

module rle_board_string_decoder
    import rbsd_pkg::*;
#(
    parameter logic [11:0] P_MAX_SIDE = C_MAX_SIDE
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rbsd_in_if.sink     i_in,
    rbsd_out_if.source  o_out
);

    logic   w_push;
    logic   w_q_ready;
    t_entry w_entry;

    rbsd_core #(
        .P_MAX_SIDE (P_MAX_SIDE)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_entry   (w_entry)
    );

    rbsd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_ready (w_q_ready),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

/* rtl/rbsd_core.sv */
`default_nettype none

module rbsd_core
    import rbsd_pkg::*;
#(
    parameter logic [11:0] P_MAX_SIDE = C_MAX_SIDE
)
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    rbsd_in_if.sink i_in,
    input  logic   i_q_ready,
    output logic   o_push,
    output t_entry o_entry
);

    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_last;

    t_phase     r_phase,  n_phase;
    logic [8:0] r_height, n_height;
    logic [7:0] r_width,  n_width;
    logic [8:0] r_accum,  n_accum;
    logic [8:0] r_rows,   n_rows;
    t_err       r_final,  n_final;
    t_row       r_row,    n_row;

    logic        w_consume;
    logic        w_digit;
    logic [3:0]  w_dval;
    logic        w_letter_ok;
    t_kind       w_letter_kind;
    t_close      w_cr_a;
    t_close      w_cr_b;
    logic        w_cell_v;
    t_kind       w_cell_type;
    logic [15:0] w_cell_start;
    logic [7:0]  w_cell_len;
    t_err        w_status;
    logic [7:0]  w_out_width;
    logic [7:0]  w_out_height;

    function automatic logic [8:0] f_dec_acc(input logic [8:0] acc, input logic [3:0] d);
        logic [12:0] v;
        v = {4'b0, acc} * 13'd10 + {9'b0, d};
        return (v > {4'b0, C_SAT9}) ? C_SAT9 : v[8:0];
    endfunction

    function automatic logic [8:0] f_sat_inc(input logic [8:0] a);
        return (a == C_SAT9) ? C_SAT9 : a + 9'd1;
    endfunction

    function automatic t_close f_close(input t_row row, input logic [7:0] width);
        t_close     res;
        logic [9:0] s;
        res.row   = row;
        res.emit  = 1'b0;
        res.typ   = row.kind;
        res.start = row.idx;
        res.len   = row.count[8] ? 8'hFF : row.count[7:0];
        s = {1'b0, row.count} + {1'b0, row.sum};
        res.row.sum = s[9] ? C_SAT9 : s[8:0];
        if (row.pending == ERR_NONE) begin
            if (res.row.sum > {1'b0, width}) begin
                res.row.pending = ERR_DIMS;
            end else if (row.kind == KIND_SNAKE && (row.snake || row.count > 9'd1)) begin
                res.row.pending = ERR_SNAKE;
            end else begin
                if (row.kind == KIND_SNAKE && row.count == 9'd1) begin
                    res.row.snake = 1'b1;
                end
                if (row.count != 9'd0) begin
                    res.emit    = 1'b1;
                    res.row.idx = row.idx + {7'b0, row.count};
                end
            end
        end
        return res;
    endfunction

    function automatic t_row f_close_row(input t_row row, input logic [7:0] width);
        t_row res;
        res = row;
        if (row.pending == ERR_NONE && row.sum != {1'b0, width}) begin
            res.pending = ERR_DIMS;
        end
        return res;
    endfunction

    assign w_consume   = r_in_valid && i_q_ready;
    assign i_in.ready  = !r_in_valid || i_q_ready;
    assign w_digit     = (r_char >= C_CH_0) && (r_char <= C_CH_9);
    assign w_dval      = r_char[3:0];
    assign w_letter_ok = (r_char == C_CH_W) || (r_char == C_CH_E) || (r_char == C_CH_S);

    always_comb begin
        priority if (r_char == C_CH_W) begin
            w_letter_kind = KIND_WALL;
        end else if (r_char == C_CH_S) begin
            w_letter_kind = KIND_SNAKE;
        end else begin
            w_letter_kind = KIND_EMPTY;
        end
    end

    // next state: the byte, then the end-of-string checks when it is the last one
    always_comb begin
        n_phase  = r_phase;
        n_height = r_height;
        n_width  = r_width;
        n_accum  = r_accum;
        n_rows   = r_rows;
        n_final  = r_final;
        n_row    = r_row;
        w_cr_a   = f_close(r_row, r_width);
        w_cr_b   = f_close(r_row, r_width);
        w_cell_v     = 1'b0;
        w_cell_type  = KIND_EMPTY;
        w_cell_start = 16'd0;
        w_cell_len   = 8'd0;

        if (r_final == ERR_NONE) begin
            unique case (r_phase)
                PH_HDR_B: begin
                    if (r_char == C_CH_B) begin
                        n_phase = PH_HGT0;
                    end else if (r_char != C_CH_BAR) begin
                        n_final = ERR_DIMS;
                    end
                end
                PH_HGT0, PH_HGT: begin
                    if (w_digit) begin
                        n_accum = f_dec_acc(r_accum, w_dval);
                        n_phase = PH_HGT;
                    end else if (r_char == C_CH_X && r_phase == PH_HGT) begin
                        n_height = r_accum;
                        n_accum  = 9'd0;
                        n_phase  = PH_WID0;
                    end else begin
                        n_final = ERR_DIMS;
                    end
                end
                PH_WID0, PH_WID: begin
                    if (w_digit) begin
                        n_accum = f_dec_acc(r_accum, w_dval);
                        n_phase = PH_WID;
                    end else if (r_char == C_CH_BAR && r_phase == PH_WID) begin
                        n_width = r_accum[7:0];
                        if ({3'b0, r_accum} > P_MAX_SIDE || {3'b0, r_height} > P_MAX_SIDE) begin
                            n_final = ERR_DIMS;
                        end
                        n_height = {1'b0, r_height[7:0]};
                        n_accum  = 9'd0;
                        n_phase  = PH_ROWSTART;
                    end else begin
                        n_final = ERR_DIMS;
                    end
                end
                PH_ROWSTART: begin
                    if (r_char != C_CH_BAR) begin
                        n_rows = f_sat_inc(r_rows);
                        if (n_rows > r_height) begin
                            n_final = ERR_DIMS;
                        end else begin
                            n_row.sum     = 9'd0;
                            n_row.pending = ERR_NONE;
                            if (!w_letter_ok) begin
                                n_final = ERR_CHAR;
                            end else begin
                                n_row.kind  = w_letter_kind;
                                n_row.count = 9'd0;
                                n_phase     = PH_RUN;
                            end
                        end
                    end
                end
                default: begin
                    if (w_digit) begin
                        n_row.count = f_dec_acc(r_row.count, w_dval);
                    end else if (r_char == C_CH_BAR) begin
                        n_row = f_close_row(w_cr_a.row, r_width);
                        if (n_row.pending != ERR_NONE) begin
                            n_final = n_row.pending;
                        end
                        n_phase = PH_ROWSTART;
                        if (w_cr_a.emit) begin
                            w_cell_v     = 1'b1;
                            w_cell_type  = w_cr_a.typ;
                            w_cell_start = w_cr_a.start;
                            w_cell_len   = w_cr_a.len;
                        end
                    end else if (!w_letter_ok) begin
                        n_final = ERR_CHAR;
                    end else begin
                        n_row       = w_cr_a.row;
                        n_row.kind  = w_letter_kind;
                        n_row.count = 9'd0;
                        if (w_cr_a.emit) begin
                            w_cell_v     = 1'b1;
                            w_cell_type  = w_cr_a.typ;
                            w_cell_start = w_cr_a.start;
                            w_cell_len   = w_cr_a.len;
                        end
                    end
                end
            endcase
        end

        if (r_last && n_final == ERR_NONE) begin
            if (n_phase == PH_WID) begin
                if ({3'b0, n_accum} > P_MAX_SIDE || {3'b0, n_height} > P_MAX_SIDE) begin
                    n_final = ERR_DIMS;
                end
                n_width  = n_accum[7:0];
                n_height = {1'b0, n_height[7:0]};
                n_accum  = 9'd0;
                n_phase  = PH_ROWSTART;
            end else if (n_phase == PH_RUN) begin
                // the run still open at the end of the string
                w_cr_b = f_close(n_row, n_width);
                n_row  = f_close_row(w_cr_b.row, n_width);
                if (n_row.pending != ERR_NONE) begin
                    n_final = n_row.pending;
                end
                n_phase = PH_ROWSTART;
                if (w_cr_b.emit) begin
                    w_cell_v     = 1'b1;
                    w_cell_type  = w_cr_b.typ;
                    w_cell_start = w_cr_b.start;
                    w_cell_len   = w_cr_b.len;
                end
            end else if (n_phase != PH_ROWSTART) begin
                n_final = ERR_DIMS;
            end
            if (n_final == ERR_NONE) begin
                if (n_rows != n_height) begin
                    n_final = ERR_DIMS;
                end else if (!n_row.snake) begin
                    n_final = ERR_SNAKE;
                end
            end
        end

        w_status     = n_final;
        w_out_width  = n_width;
        w_out_height = n_height[7:0];

        // rearm for the next string
        if (r_last) begin
            n_phase  = PH_HDR_B;
            n_height = 9'd0;
            n_width  = 8'd0;
            n_accum  = 9'd0;
            n_rows   = 9'd0;
            n_final  = ERR_NONE;
            n_row    = '0;
        end
    end

    always_comb begin
        o_push               = w_consume && (w_cell_v || r_last);
        o_entry.cell_v       = w_cell_v;
        o_entry.cell_type    = w_cell_type;
        o_entry.start_index  = w_cell_start;
        o_entry.run_length   = w_cell_len;
        o_entry.status_v     = r_last;
        o_entry.status_code  = w_status;
        o_entry.board_width  = w_out_width;
        o_entry.board_height = w_out_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_HDR_B;
            r_height   <= 9'd0;
            r_width    <= 8'd0;
            r_accum    <= 9'd0;
            r_rows     <= 9'd0;
            r_final    <= ERR_NONE;
            r_row      <= '0;
        end else begin
            r_in_valid <= (i_in.valid && i_in.ready) || (r_in_valid && !i_q_ready);
            if (w_consume) begin
                r_phase  <= n_phase;
                r_height <= n_height;
                r_width  <= n_width;
                r_accum  <= n_accum;
                r_rows   <= n_rows;
                r_final  <= n_final;
                r_row    <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_char <= i_in.char_code;
            r_last <= i_in.is_last;
        end
    end

`ifndef ASSERT_OFF
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && r_last) |-> (o_push && o_entry.status_v))
        else $error("last byte did not produce a status");

    a_last_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && r_last) |=> (r_phase == PH_HDR_B && r_final == ERR_NONE))
        else $error("parser not rearmed after last byte");

    a_cell_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_entry.cell_v) |-> (o_entry.run_length != 8'd0))
        else $error("empty cell run emitted");
`endif

endmodule

`default_nettype wire

/* rtl/rbsd_outq.sv */
`default_nettype none

module rbsd_outq
    import rbsd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_entry       i_entry,
    output logic         o_ready,
    rbsd_out_if.source   o_out
);

    t_entry     r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       r_sub;

    t_entry     w_head;
    logic       w_show_cell;
    logic       w_pop;

    assign w_head      = r_mem[r_rptr];
    // the cell run of an entry goes first, its status after
    assign w_show_cell = w_head.cell_v && !r_sub;
    assign w_pop       = o_out.valid && o_out.ready && (!w_show_cell || !w_head.status_v);
    assign o_ready     = (r_count != 2'd2);

    assign o_out.valid        = (r_count != 2'd0);
    assign o_out.result_kind  = !w_show_cell;
    assign o_out.cell_type    = w_show_cell ? w_head.cell_type : KIND_EMPTY;
    assign o_out.start_index  = w_show_cell ? w_head.start_index : 16'd0;
    assign o_out.run_length   = w_show_cell ? w_head.run_length : 8'd0;
    assign o_out.status_code  = w_show_cell ? ERR_NONE : w_head.status_code;
    assign o_out.board_width  = w_head.board_width;
    assign o_out.board_height = w_head.board_height;
    assign o_out.last_result  = !w_show_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
            r_sub   <= 1'b0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
                r_sub  <= 1'b0;
            end else if (o_out.valid && o_out.ready) begin
                r_sub <= 1'b1;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2))
        else $error("push into full result queue");

    a_sub_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (r_count != 2'd0 && w_head.cell_v && w_head.status_v))
        else $error("second half of an entry without a two-result entry");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result queue count out of range");
`endif

endmodule

`default_nettype wire
